[sv/cfd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types, constants and the byte-wide CRC-32 update for the deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int unsigned HEADER_LEN = 12;
  localparam int unsigned MIN_LEN    = 14;
  localparam int unsigned CRC_BYTES  = 4;
  localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_GOOD      = 3'd1,
    KIND_CRC_ERR   = 3'd2,
    KIND_TRUNC     = 3'd3,
    KIND_MALFORMED = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_datagram;
  } in_beat_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         payload_byte;
    logic signed [63:0] sequence_res;
    logic [15:0]        command;
    logic [15:0]        payload_length;
  } res_t;

  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } in_stage_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } res_stage_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/cfd_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_if
// Valid/ready channels: received bytes in, deframer results out.
// ----------------------------------------------------------------------------
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_datagram;

  modport source (output valid, output data_byte, output last_in_datagram, input ready);
  modport sink   (input valid, input data_byte, input last_in_datagram, output ready);
endinterface

interface cfd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         payload_byte;
  logic signed [63:0] sequence_res;
  logic [15:0]        command;
  logic [15:0]        payload_length;

  modport source (output valid, output kind, output payload_byte, output sequence_res,
                  output command, output payload_length, input ready);
  modport sink   (input valid, input kind, input payload_byte, input sequence_res,
                  input command, input payload_length, output ready);
endinterface
`default_nettype wire

[sv/cfd_in_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_in_reg
// Input register: captures one byte beat, holds it until the core takes it.
// ----------------------------------------------------------------------------
module cfd_in_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  cfd_in_if.sink               in_i,
  input  wire logic            advance_i,
  output cfd_pkg::in_stage_t   stage_o
);
  import cfd_pkg::*;

  logic     valid_q, valid_d;
  in_beat_t beat_q, beat_d;
  logic     take;

  assign take       = in_i.valid && in_i.ready;
  assign in_i.ready = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    beat_d  = beat_q;
    if (advance_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d                 = 1'b1;
      beat_d.data_byte        = in_i.data_byte;
      beat_d.last_in_datagram = in_i.last_in_datagram;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign stage_o.valid = valid_q;
  assign stage_o.beat  = beat_q;
endmodule
`default_nettype wire

[sv/cfd_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_core
// Frame state, field capture, CRC update and result selection, one beat per
// cycle while the result register can take a result.
// ----------------------------------------------------------------------------
module cfd_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfd_pkg::in_stage_t   stage_i,
  input  wire logic                 advance_i,
  output cfd_pkg::res_stage_t       res_o
);
  import cfd_pkg::*;

  localparam logic [16:0] HdrLen = 17'(HEADER_LEN);
  localparam logic [15:0] MinLen = 16'(MIN_LEN);
  localparam logic [1:0]  CrcAdj = 2'(CRC_BYTES - 2);

  logic [16:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [63:0] seq_q, seq_d;
  logic [15:0] cmd_q, cmd_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rcrc_q, rcrc_d;
  logic        disc_q, disc_d;

  logic [7:0]  b;
  logic        last;
  logic        fire;
  logic [16:0] pos_p2;
  logic        in_body;
  logic        is_payload;
  logic [1:0]  crc_lane;
  logic        end_frame;
  logic        malformed;
  logic [15:0] plen_new;
  logic [31:0] crc_upd;

  assign b    = stage_i.beat.data_byte;
  assign last = stage_i.beat.last_in_datagram;
  assign fire = stage_i.valid && advance_i;

  always_comb begin
    pos_p2     = pos_q + 17'd2;
    in_body    = pos_p2 < {1'b0, len_q};
    is_payload = (pos_q >= HdrLen) && in_body;
    crc_lane   = pos_q[1:0] + CrcAdj - len_q[1:0];
    crc_upd    = crc32_byte(crc_q, b);

    len_d  = len_q;
    seq_d  = seq_q;
    cmd_d  = cmd_q;
    rcrc_d = rcrc_q;
    crc_d  = ((pos_q < 17'd2) || in_body) ? crc_upd : crc_q;

    if (pos_q == 17'd0) begin
      len_d = {8'd0, b};
    end else if (pos_q == 17'd1) begin
      len_d = {b, len_q[7:0]};
    end
    for (int i = 0; i < 8; i++) begin
      if (pos_q == 17'(i + 2)) begin
        seq_d[8*i +: 8] = seq_q[8*i +: 8] | b;
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (pos_q == 17'(i + 10)) begin
        cmd_d[8*i +: 8] = cmd_q[8*i +: 8] | b;
      end
    end
    if ((pos_q >= HdrLen) && !in_body) begin
      for (int k = 0; k < 4; k++) begin
        if (crc_lane == 2'(k)) begin
          rcrc_d[8*k +: 8] = rcrc_q[8*k +: 8] | b;
        end
      end
    end

    malformed = (pos_q == 17'd1) && (len_d < MinLen);
    end_frame = (pos_q >= 17'd2) && (pos_q == ({1'b0, len_q} + 17'd1));
    plen_new  = (len_d >= MinLen) ? (len_d - MinLen) : 16'd0;
    pos_d     = pos_q + 17'd1;
    disc_d    = disc_q;

    res_o.valid              = 1'b0;
    res_o.res.kind           = KIND_PAYLOAD;
    res_o.res.payload_byte   = 8'd0;
    res_o.res.sequence_res   = seq_d;
    res_o.res.command        = cmd_d;
    res_o.res.payload_length = plen_new;

    if (disc_q) begin
      pos_d = pos_q;
      len_d = len_q;
      seq_d = seq_q;
      cmd_d = cmd_q;
      crc_d = crc_q;
      rcrc_d = rcrc_q;
      res_o.res.sequence_res = seq_q;
      res_o.res.command      = cmd_q;
      if (last) begin
        disc_d = 1'b0;
      end
    end else if (malformed) begin
      res_o.valid    = 1'b1;
      res_o.res.kind = KIND_MALFORMED;
      disc_d         = !last;
    end else if (end_frame) begin
      res_o.valid    = 1'b1;
      res_o.res.kind = ((~crc_d) == rcrc_d) ? KIND_GOOD : KIND_CRC_ERR;
    end else if (last) begin
      res_o.valid    = 1'b1;
      res_o.res.kind = KIND_TRUNC;
      if (pos_q == 17'd0) begin
        res_o.res.payload_length = 16'd0;
      end
    end else if (is_payload) begin
      res_o.valid            = 1'b1;
      res_o.res.payload_byte = b;
    end

    if (!stage_i.valid) begin
      res_o.valid = 1'b0;
    end

    if ((disc_q && last) || (!disc_q && (malformed || end_frame || last))) begin
      pos_d  = 17'd0;
      len_d  = 16'd0;
      seq_d  = 64'd0;
      cmd_d  = 16'd0;
      crc_d  = CRC_INIT;
      rcrc_d = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 17'd0;
      len_q  <= 16'd0;
      seq_q  <= 64'd0;
      cmd_q  <= 16'd0;
      crc_q  <= CRC_INIT;
      rcrc_q <= 32'd0;
      disc_q <= 1'b0;
    end else if (fire) begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      seq_q  <= seq_d;
      cmd_q  <= cmd_d;
      crc_q  <= crc_d;
      rcrc_q <= rcrc_d;
      disc_q <= disc_d;
    end
  end
endmodule
`default_nettype wire

[sv/cfd_out_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cfd_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module cfd_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfd_pkg::res_stage_t  res_i,
  input  wire logic                 load_i,
  output logic                      free_o,
  cfd_out_if.source                 out_o
);
  import cfd_pkg::*;

  logic valid_q, valid_d;
  res_t res_q, res_d;

  assign free_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (out_o.ready) begin
      valid_d = 1'b0;
    end
    if (load_i && res_i.valid) begin
      valid_d = 1'b1;
      res_d   = res_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid          = valid_q;
  assign out_o.kind           = res_q.kind;
  assign out_o.payload_byte   = res_q.payload_byte;
  assign out_o.sequence_res   = res_q.sequence_res;
  assign out_o.command        = res_q.command;
  assign out_o.payload_length = res_q.payload_length;
endmodule
`default_nettype wire

[sv/crc32_frame_deframer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crc32_frame_deframer_unit
// Length-prefixed frame deframer with CRC-32 check.
// ----------------------------------------------------------------------------
// Takes one datagram byte per beat and accepts a new byte every cycle while
// the result side does not stall; each byte's result passes from the input
// register through the core into the result register. The rate is set by
// the loop that updates the frame state and the byte-wide CRC-32 per byte.
// Payload bytes come out as they arrive, and every frame ends with one status
// beat (good, CRC error, truncated, malformed). After a malformed frame the
// rest of the datagram is dropped. Back-pressure on the result side stalls
// input only once both the input and the result register are full.
module crc32_frame_deframer_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cfd_in_if.sink     in_i,
  cfd_out_if.source  res_o
);
  import cfd_pkg::*;

  in_stage_t  in_stage;
  res_stage_t core_res;
  logic       advance;

  cfd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .stage_o   (in_stage)
  );

  cfd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (in_stage),
    .advance_i (advance),
    .res_o     (core_res)
  );

  cfd_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (core_res),
    .load_i (advance),
    .free_o (advance),
    .out_o  (res_o)
  );
endmodule
`default_nettype wire
